// ----- src/gbfcr_pkg.sv -----
package gbfcr_pkg;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_FIRST    = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_SECOND   = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SYNC_THIRD    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_HEADER_BYTES  = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH_OFFSET = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_ID_OFFSET     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_MAX_PAYLOAD   = 3'd6;

    localparam logic [7:0]  RST_SYNC_FIRST    = 8'd170;
    localparam logic [7:0]  RST_SYNC_SECOND   = 8'd68;
    localparam logic [7:0]  RST_SYNC_THIRD    = 8'd18;
    localparam logic [7:0]  RST_HEADER_BYTES  = 8'd28;
    localparam logic [7:0]  RST_LENGTH_OFFSET = 8'd8;
    localparam logic [7:0]  RST_ID_OFFSET     = 8'd4;
    localparam logic [15:0] RST_MAX_PAYLOAD   = 16'd1024;

    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    typedef enum logic [5:0] {
        PH_SYNC1 = 6'b000001,
        PH_SYNC2 = 6'b000010,
        PH_SYNC3 = 6'b000100,
        PH_HEAD  = 6'b001000,
        PH_DATA  = 6'b010000,
        PH_CRC   = 6'b100000
    } phase_t;

    // Reflected CRC32, one byte per call, no init or final xor.
    function automatic logic [31:0] crc_feed(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] t;
        t = {24'd0, crc[7:0] ^ b};
        for (int k = 0; k < 8; k++)
        begin
            t = t[0] ? ((t >> 1) ^ CRC_POLY) : (t >> 1);
        end
        return {8'd0, crc[31:8]} ^ t;
    endfunction

endpackage

// ----- src/gnss_binary_frame_crc32_receiver_unit.sv -----
// Binary frame receiver: sync search, header field capture, CRC32 check.
// Bytes pass from the input register through the frame FSM to the result register.
// Throughput: one byte per cycle, but the last CRC byte waits for a free result
//   slot; the byte-wide CRC update and the frame FSM sit in one stage between
//   the input register and the result register.
// Reset (rst_n, async, active low): waiting for first sync, registers at defaults.
module gnss_binary_frame_crc32_receiver_unit
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [7:0]                         data_byte,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [15:0]                        msg_id,
    output logic [15:0]                        msg_length,
    output logic                               crc_ok,
    input  logic                               cfg_write,
    input  logic [gbfcr_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [gbfcr_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import gbfcr_pkg::*;

    logic [7:0]  sync_first_reg, sync_second_reg, sync_third_reg;
    logic [7:0]  header_bytes_reg, length_offset_reg, id_offset_reg;
    logic [15:0] max_payload_reg;

    logic        s1_valid_reg;
    logic [7:0]  s1_data_reg;

    phase_t      phase_reg, phase_next;
    logic [16:0] byte_index_reg, byte_index_next;
    logic [15:0] payload_len_reg, payload_len_next;
    logic [15:0] message_id_reg, message_id_next;
    logic [31:0] running_crc_reg, running_crc_next;
    logic [31:0] received_crc_reg, received_crc_next;
    logic [1:0]  crc_pos_reg, crc_pos_next;

    logic        out_valid_reg;
    logic [15:0] msg_id_reg, msg_length_reg;
    logic        crc_ok_reg;

    logic        out_free, last_crc, s1_fire, in_accept, result_load;
    logic [31:0] crc_d;
    logic [8:0]  pos9, idx_inc9;
    logic [16:0] data_inc;

    // Config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg    <= RST_SYNC_FIRST;
            sync_second_reg   <= RST_SYNC_SECOND;
            sync_third_reg    <= RST_SYNC_THIRD;
            header_bytes_reg  <= RST_HEADER_BYTES;
            length_offset_reg <= RST_LENGTH_OFFSET;
            id_offset_reg     <= RST_ID_OFFSET;
            max_payload_reg   <= RST_MAX_PAYLOAD;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:    sync_first_reg    <= cfg_data[7:0];
                CFG_SYNC_SECOND:   sync_second_reg   <= cfg_data[7:0];
                CFG_SYNC_THIRD:    sync_third_reg    <= cfg_data[7:0];
                CFG_HEADER_BYTES:  header_bytes_reg  <= cfg_data[7:0];
                CFG_LENGTH_OFFSET: length_offset_reg <= cfg_data[7:0];
                CFG_ID_OFFSET:     id_offset_reg     <= cfg_data[7:0];
                CFG_MAX_PAYLOAD:   max_payload_reg   <= cfg_data[15:0];
                default:           ;
            endcase
        end
    end

    // Handshake: only the last CRC byte needs a free result slot
    assign out_free  = !out_valid_reg || !out_stall;
    assign last_crc  = (phase_reg == PH_CRC) && (crc_pos_reg == 2'd3);
    assign s1_fire   = s1_valid_reg && (out_free || !last_crc);
    assign in_stall  = s1_valid_reg && !s1_fire;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_fire)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_data_reg <= data_byte;
        end
    end

    // Frame FSM
    assign crc_d    = crc_feed(running_crc_reg, s1_data_reg);
    assign pos9     = {1'b0, byte_index_reg[7:0]};
    assign idx_inc9 = pos9 + 9'd1;
    assign data_inc = byte_index_reg + 17'd1;

    always_comb
    begin
        phase_next        = phase_reg;
        byte_index_next   = byte_index_reg;
        payload_len_next  = payload_len_reg;
        message_id_next   = message_id_reg;
        running_crc_next  = running_crc_reg;
        received_crc_next = received_crc_reg;
        crc_pos_next      = crc_pos_reg;
        result_load       = 1'b0;
        case (phase_reg)
            PH_SYNC1:
            begin
                if (s1_data_reg == sync_first_reg)
                begin
                    running_crc_next = crc_feed(32'd0, s1_data_reg);
                    byte_index_next  = 17'd1;
                    payload_len_next = 16'd0;
                    message_id_next  = 16'd0;
                    phase_next       = PH_SYNC2;
                end
            end
            PH_SYNC2:
            begin
                if (s1_data_reg == sync_second_reg)
                begin
                    running_crc_next = crc_d;
                    byte_index_next  = 17'd2;
                    phase_next       = PH_SYNC3;
                end
            end
            PH_SYNC3:
            begin
                if (s1_data_reg == sync_third_reg)
                begin
                    running_crc_next = crc_d;
                    byte_index_next  = 17'd3;
                    phase_next       = PH_HEAD;
                end
            end
            PH_HEAD:
            begin
                running_crc_next = crc_d;
                if (pos9 == {1'b0, length_offset_reg})
                    payload_len_next[7:0] = s1_data_reg;
                if (pos9 == ({1'b0, length_offset_reg} + 9'd1))
                    payload_len_next[15:8] = s1_data_reg;
                if (pos9 == {1'b0, id_offset_reg})
                    message_id_next[7:0] = s1_data_reg;
                if (pos9 == ({1'b0, id_offset_reg} + 9'd1))
                    message_id_next[15:8] = s1_data_reg;
                byte_index_next = {8'd0, idx_inc9};
                if (idx_inc9 >= {1'b0, header_bytes_reg})
                begin
                    if (payload_len_next > max_payload_reg)
                    begin
                        phase_next = PH_SYNC1;
                    end
                    else if (payload_len_next == 16'd0)
                    begin
                        received_crc_next = 32'd0;
                        crc_pos_next      = 2'd0;
                        phase_next        = PH_CRC;
                    end
                    else
                    begin
                        byte_index_next = 17'd0;
                        phase_next      = PH_DATA;
                    end
                end
            end
            PH_DATA:
            begin
                running_crc_next = crc_d;
                byte_index_next  = data_inc;
                if (data_inc >= {1'b0, payload_len_reg})
                begin
                    received_crc_next = 32'd0;
                    crc_pos_next      = 2'd0;
                    phase_next        = PH_CRC;
                end
            end
            PH_CRC:
            begin
                // CRC arrives LSB first
                received_crc_next = received_crc_reg
                                  | ({24'd0, s1_data_reg} << {crc_pos_reg, 3'b000});
                crc_pos_next = crc_pos_reg + 2'd1;
                if (crc_pos_reg == 2'd3)
                begin
                    result_load = 1'b1;
                    phase_next  = PH_SYNC1;
                end
            end
            default:
            begin
                phase_next = PH_SYNC1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_SYNC1;
            byte_index_reg   <= 17'd0;
            payload_len_reg  <= 16'd0;
            message_id_reg   <= 16'd0;
            running_crc_reg  <= 32'd0;
            received_crc_reg <= 32'd0;
            crc_pos_reg      <= 2'd0;
        end
        else if (s1_fire)
        begin
            phase_reg        <= phase_next;
            byte_index_reg   <= byte_index_next;
            payload_len_reg  <= payload_len_next;
            message_id_reg   <= message_id_next;
            running_crc_reg  <= running_crc_next;
            received_crc_reg <= received_crc_next;
            crc_pos_reg      <= crc_pos_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && result_load)
        begin
            msg_id_reg     <= message_id_reg;
            msg_length_reg <= payload_len_reg;
            crc_ok_reg     <= (received_crc_next == running_crc_reg);
        end
    end

    assign out_valid  = out_valid_reg;
    assign msg_id     = msg_id_reg;
    assign msg_length = msg_length_reg;
    assign crc_ok     = crc_ok_reg;

`ifndef SYNTHESIS
    a_crc_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg != PH_CRC) |-> (crc_pos_reg == 2'd0))
        else $error("crc byte position nonzero outside CRC phase");

    a_data_index: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_DATA) |-> (byte_index_reg < {1'b0, payload_len_reg}))
        else $error("payload byte index past length");

    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(phase_reg == PH_CRC && crc_pos_reg == 2'd3))
        else $error("result request without last CRC byte");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(s1_fire && result_load))
        else $error("pending result request overwritten");
`endif

endmodule
